/* hdl/txn_timestamp_watermark_manager_core_macros.svh */
// Assertion macros for the timestamp watermark manager core.
`ifndef TXN_TIMESTAMP_WATERMARK_MANAGER_CORE_MACROS_SVH
`define TXN_TIMESTAMP_WATERMARK_MANAGER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TTWM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TTWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ttwm_pkg.sv */
// Shared types and constants of the timestamp watermark manager.
package ttwm_pkg;

    // Default number of thread table entries.
    localparam int unsigned MAX_THREADS_DEF = 64;
    // Thread ids are six bits wide, so no more entries are ever written.
    localparam int unsigned TID_SPAN = 64;

    localparam logic [63:0] IDLE_TS = '1;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Request kinds.
    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_PUBLISH = 2'd1;
    localparam logic [1:0] KIND_QUERY   = 2'd2;

    // Timestamp sources.
    localparam logic [1:0] TS_PRE_INC     = 2'd0;
    localparam logic [1:0] TS_FETCH_ONE   = 2'd1;
    localparam logic [1:0] TS_FETCH_BATCH = 2'd2;
    localparam logic [1:0] TS_NOW_SCALED  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TS_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BATCH_SIZE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THREAD_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_MODE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOGGER_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_PUB,
        ST_SCAN
    } t_state;

    // Input word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  thr_idx;
        logic [63:0] ts_value;
        logic [63:0] now;
    } t_req;

    // Result word.
    typedef struct packed {
        logic [63:0] result_value;
        logic        order_error;
    } t_rsp;

    // Status of the minimum scan unit.
    typedef struct packed {
        logic rd_en;
        logic done;
    } t_scan_st;

endpackage

/* hdl/ttwm_table_mem.sv */
// Thread timestamp table: synchronous memory with per-entry valid bits.
module ttwm_table_mem
    import ttwm_pkg::*;
#(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [63:0]       i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [63:0]       o_rdata
);

    logic [63:0]      r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [63:0]      r_rdata;
    logic             r_rvld;

    // Storage array with one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    // Valid bits make never-written entries read as idle after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rvld <= r_vld[i_raddr];
            end
        end
    end

    assign o_rdata = r_rvld ? r_rdata : IDLE_TS;

endmodule

/* hdl/ttwm_min_scan.sv */
// Minimum scan unit: walks the table one entry per cycle.
module ttwm_min_scan
    import ttwm_pkg::*;
#(
    parameter int unsigned CNT_W  = 7,
    parameter int unsigned ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [CNT_W-1:0]  i_limit,
    input  logic [63:0]       i_rd_data,
    output t_scan_st          o_st,
    output logic [ADDR_W-1:0] o_rd_addr,
    output logic [63:0]       o_min
);

    logic             r_act;
    logic             r_pend;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_lim;
    logic [63:0]      r_min;

    logic             n_act;
    logic             n_pend;
    logic [CNT_W-1:0] n_idx;
    logic [63:0]      n_min;

    // Issue one read per cycle and fold in the data of the previous read.
    always_comb begin
        n_act      = r_act;
        n_pend     = 1'b0;
        n_idx      = r_idx;
        n_min      = r_min;
        o_st.rd_en = 1'b0;
        o_st.done  = 1'b0;
        if (r_act) begin
            if (r_pend && (i_rd_data < r_min)) begin
                n_min = i_rd_data;
            end
            if (r_idx < r_lim) begin
                o_st.rd_en = 1'b1;
                n_idx      = r_idx + CNT_W'(1);
                n_pend     = 1'b1;
            end else if (!r_pend) begin
                o_st.done = 1'b1;
                n_act     = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_pend <= 1'b0;
        end else if (i_start) begin
            r_act  <= 1'b1;
            r_pend <= 1'b0;
        end else begin
            r_act  <= n_act;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_idx <= '0;
            r_lim <= i_limit;
            r_min <= IDLE_TS;
        end else begin
            r_idx <= n_idx;
            r_min <= n_min;
        end
    end

    assign o_rd_addr = r_idx[ADDR_W-1:0];
    assign o_min     = r_min;

endmodule

/* hdl/txn_timestamp_watermark_manager_core.sv */
// Top level of the transaction timestamp allocator with low watermark.
//
// Takes one word at a time: a request is accepted when i_start is high and
// o_busy is low, and its result appears for one cycle with o_done from a
// register; the receiver cannot stall. Counter allocations, queries without a
// rescan, the unused fourth kind and out-of-range publishes outside recovery
// mode finish without leaving the idle state, so a new word may be accepted in
// the very next cycle. Clock-based allocation passes through one multiply
// stage. An in-range publish first reads the old thread entry from the table
// memory, then checks it and writes the new value back. A watermark rescan
// (query from thread 0 after the interval outside recovery mode, or any publish
// in recovery mode) walks the table through its single read port, one entry per
// cycle, reading min(count, table depth) entries. The table needs no clearing
// pass: per-entry valid bits cleared by reset make it read idle.
module txn_timestamp_watermark_manager_core
    import ttwm_pkg::*;
#(
    parameter int unsigned MAX_THREADS = MAX_THREADS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_req                  i_req,
    output logic                  o_done,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "txn_timestamp_watermark_manager_core_macros.svh"

    // Table depth is clamped to the thread id range; higher thread ids are never written.
    localparam int unsigned TBL_DEPTH = (MAX_THREADS < TID_SPAN) ? MAX_THREADS : TID_SPAN;
    localparam int unsigned ADDR_W    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
    localparam int unsigned CNT_W     = $clog2(TBL_DEPTH + 1);

    // Configuration registers.
    logic [1:0]  r_ts_mode;
    logic [15:0] r_batch_size;
    logic [6:0]  r_thread_count;
    logic        r_recover;
    logic [6:0]  r_logger_count;
    logic [31:0] r_min_interval;

    // Control and architectural state.
    t_state      r_state, n_state;
    logic [63:0] r_cnt, n_cnt;
    logic [63:0] r_wm, n_wm;
    logic [63:0] r_last, n_last;
    logic        r_done, n_done;
    t_req        r_req, n_req;
    t_rsp        r_rsp, n_rsp;
    logic        r_err, n_err;
    logic        r_scan_rec, n_scan_rec;

    // Table and scan connections.
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [63:0]       tbl_rdata;
    logic              scan_go;
    logic              use_logger;
    logic [6:0]        lim_src;
    logic [CNT_W-1:0]  scan_lim;
    t_scan_st          scan_st;
    logic [ADDR_W-1:0] scan_addr;
    logic [63:0]       scan_min;

    logic              tid_in_tbl;
    logic              rescan_due;
    logic              pub_err;
    logic [63:0]       mul_prod;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts_mode      <= TS_FETCH_ONE;
            r_batch_size   <= 16'd1;
            r_thread_count <= 7'd64;
            r_recover      <= 1'b0;
            r_logger_count <= 7'd1;
            r_min_interval <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TS_MODE:      r_ts_mode      <= i_cfg_data[1:0];
                CFG_BATCH_SIZE:   r_batch_size   <= i_cfg_data[15:0];
                CFG_THREAD_COUNT: r_thread_count <= i_cfg_data[6:0];
                CFG_RECOVER_MODE: r_recover      <= i_cfg_data[0];
                CFG_LOGGER_COUNT: r_logger_count <= i_cfg_data[6:0];
                CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Request decode helpers.
    assign tid_in_tbl = ({1'b0, i_req.thr_idx} < 7'(TBL_DEPTH));
    assign rescan_due = !r_recover && (i_req.thr_idx == '0) &&
                        ((i_req.now - r_last) > {32'b0, r_min_interval});
    assign pub_err    = (tbl_rdata != IDLE_TS) && (r_req.ts_value < tbl_rdata);
    assign mul_prod   = r_req.now * {57'b0, r_thread_count};

    // Scan length is the selected count clamped to the table depth.
    assign lim_src  = use_logger ? r_logger_count : r_thread_count;
    assign scan_lim = (lim_src > 7'(TBL_DEPTH)) ? CNT_W'(TBL_DEPTH) : lim_src[CNT_W-1:0];

    // Sequencer: next state, state updates and table accesses.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_wm       = r_wm;
        n_last     = r_last;
        n_req      = r_req;
        n_rsp      = r_rsp;
        n_err      = r_err;
        n_scan_rec = r_scan_rec;
        n_done     = 1'b0;
        scan_go    = 1'b0;
        use_logger = 1'b0;
        rd_en      = scan_st.rd_en;
        rd_addr    = scan_addr;
        wr_en      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_req              = i_req;
                    n_err              = 1'b0;
                    n_rsp.result_value = r_wm;
                    n_rsp.order_error  = 1'b0;
                    unique case (i_req.kind)
                        KIND_ALLOC: begin
                            unique case (r_ts_mode)
                                TS_PRE_INC: begin
                                    n_cnt              = r_cnt + 64'd1;
                                    n_rsp.result_value = r_cnt + 64'd1;
                                    n_done             = 1'b1;
                                end
                                TS_FETCH_ONE: begin
                                    n_cnt              = r_cnt + 64'd1;
                                    n_rsp.result_value = r_cnt;
                                    n_done             = 1'b1;
                                end
                                TS_FETCH_BATCH: begin
                                    n_cnt              = r_cnt + {48'b0, r_batch_size};
                                    n_rsp.result_value = r_cnt;
                                    n_done             = 1'b1;
                                end
                                TS_NOW_SCALED: begin
                                    n_state = ST_MUL;
                                end
                            endcase
                        end
                        KIND_PUBLISH: begin
                            if (tid_in_tbl) begin
                                rd_en   = 1'b1;
                                rd_addr = i_req.thr_idx[ADDR_W-1:0];
                                n_state = ST_PUB;
                            end else if (r_recover) begin
                                scan_go    = 1'b1;
                                use_logger = 1'b1;
                                n_scan_rec = 1'b1;
                                n_state    = ST_SCAN;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        KIND_QUERY: begin
                            if (rescan_due) begin
                                scan_go    = 1'b1;
                                n_scan_rec = 1'b0;
                                n_state    = ST_SCAN;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                n_rsp.result_value = mul_prod + {58'b0, r_req.thr_idx};
                n_rsp.order_error  = 1'b0;
                n_done             = 1'b1;
                n_state            = ST_IDLE;
            end
            ST_PUB: begin
                // Old entry arrives this cycle; check it and write the new one.
                wr_en = 1'b1;
                n_err = pub_err;
                if (r_recover) begin
                    scan_go    = 1'b1;
                    use_logger = 1'b1;
                    n_scan_rec = 1'b1;
                    n_state    = ST_SCAN;
                end else begin
                    n_rsp.result_value = r_wm;
                    n_rsp.order_error  = pub_err;
                    n_done             = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (scan_st.done) begin
                    if (r_scan_rec) begin
                        n_wm = scan_min;
                    end else begin
                        if (scan_min > r_wm) begin
                            n_wm = scan_min;
                        end
                        n_last = r_req.now;
                    end
                    n_rsp.result_value = n_wm;
                    n_rsp.order_error  = r_err;
                    n_done             = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
        endcase
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= 64'd1;
            r_wm    <= '0;
            r_last  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wm    <= n_wm;
            r_last  <= n_last;
            r_done  <= n_done;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_rsp      <= n_rsp;
        r_err      <= n_err;
        r_scan_rec <= n_scan_rec;
    end

    ttwm_table_mem #(
        .DEPTH  (TBL_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (wr_en),
        .i_waddr (r_req.thr_idx[ADDR_W-1:0]),
        .i_wdata (r_req.ts_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (tbl_rdata)
    );

    ttwm_min_scan #(
        .CNT_W  (CNT_W),
        .ADDR_W (ADDR_W)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_go),
        .i_limit   (scan_lim),
        .i_rd_data (tbl_rdata),
        .o_st      (scan_st),
        .o_rd_addr (scan_addr),
        .o_min     (scan_min)
    );

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // Checks on the sequencer and the watermark.
    `TTWM_ASSERT_NEXT(a_mul_done, r_state == ST_MUL, o_done && !o_busy, "clock alloc stuck")
    `TTWM_ASSERT_NEXT(a_wm_mono, (r_state == ST_SCAN) && !r_scan_rec, r_wm >= $past(r_wm), "wm fell")
    `TTWM_ASSERT_SAME(a_pub_read, r_state == ST_PUB, $past(rd_en), "publish without a read")

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the transaction timestamp watermark manager core.
`timescale 1ns / 1ps

module tb_top;
    import ttwm_pkg::*;

    // The fourth request kind is unused by the block and must return the watermark.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 80;
    localparam int RAND_PHASES   = 7;
    localparam int PHASE_WORDS   = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_req                  i_req;
    logic                  o_done;
    t_rsp                  o_rsp;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    txn_timestamp_watermark_manager_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_req      (i_req),
        .o_done     (o_done),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the block's registers and state.
    logic [1:0]  cfg_mode;
    logic [15:0] cfg_batch;
    logic [6:0]  cfg_threads;
    logic        cfg_recover;
    logic [6:0]  cfg_loggers;
    logic [31:0] cfg_interval;
    logic [63:0] alloc_ctr;
    logic [63:0] thread_slot [64];
    logic [63:0] low_mark;
    logic [63:0] scan_stamp;

    // Results still owed by the block, oldest first.
    t_rsp rsp_due [$];
    t_rsp want;

    // Stimulus state: the system clock seen by requests and the last
    // timestamp handed to each thread.
    logic [63:0] sys_now;
    logic [63:0] pub_last [64];
    bit          quiet_sender;

    int n_fail;
    int n_checked;
    int n_words;
    int n_alloc;
    int n_publish;
    int n_query;
    int n_unused;
    int n_setups;
    int stall_run;

    task automatic reset_model();
        cfg_mode     = TS_FETCH_ONE;
        cfg_batch    = 16'd1;
        cfg_threads  = 7'd64;
        cfg_recover  = 1'b0;
        cfg_loggers  = 7'd1;
        cfg_interval = 32'd0;
        alloc_ctr    = 64'd1;
        for (int i = 0; i < 64; i++) begin
            thread_slot[i] = IDLE_TS;
            pub_last[i]    = IDLE_TS;
        end
        low_mark   = 64'd0;
        scan_stamp = 64'd0;
    endtask

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TS_MODE:      cfg_mode     = data[1:0];
            CFG_BATCH_SIZE:   cfg_batch    = data[15:0];
            CFG_THREAD_COUNT: cfg_threads  = data[6:0];
            CFG_RECOVER_MODE: cfg_recover  = data[0];
            CFG_LOGGER_COUNT: cfg_loggers  = data[6:0];
            CFG_MIN_INTERVAL: cfg_interval = data;
            default: ;
        endcase
    endfunction

    // Smallest entry among the first count threads; idle when none are scanned.
    function automatic logic [63:0] slot_floor(logic [6:0] count);
        logic [63:0] m;
        m = IDLE_TS;
        for (int i = 0; i < 64 && i < count; i++) begin
            if (thread_slot[i] < m) begin
                m = thread_slot[i];
            end
        end
        return m;
    endfunction

    // Expected result of one accepted request word; updates the shadow state.
    function automatic t_rsp predict_word(t_req w);
        t_rsp        r;
        logic [63:0] old;
        logic [63:0] m;
        r = '0;
        case (w.kind)
            KIND_ALLOC: begin
                case (cfg_mode)
                    TS_PRE_INC: begin
                        alloc_ctr      = alloc_ctr + 64'd1;
                        r.result_value = alloc_ctr;
                    end
                    TS_FETCH_ONE: begin
                        r.result_value = alloc_ctr;
                        alloc_ctr      = alloc_ctr + 64'd1;
                    end
                    TS_FETCH_BATCH: begin
                        r.result_value = alloc_ctr;
                        alloc_ctr      = alloc_ctr + {48'd0, cfg_batch};
                    end
                    default: begin
                        r.result_value = w.now * {57'd0, cfg_threads} + {58'd0, w.thr_idx};
                    end
                endcase
            end
            KIND_PUBLISH: begin
                old = thread_slot[w.thr_idx];
                if (old != IDLE_TS && w.ts_value < old) begin
                    r.order_error = 1'b1;
                end
                thread_slot[w.thr_idx] = w.ts_value;
                if (cfg_recover) begin
                    low_mark = slot_floor(cfg_loggers);
                end
                r.result_value = low_mark;
            end
            KIND_QUERY: begin
                if (!cfg_recover && w.thr_idx == 6'd0 &&
                    (w.now - scan_stamp) > {32'd0, cfg_interval}) begin
                    m = slot_floor(cfg_threads);
                    if (m > low_mark) begin
                        low_mark = m;
                    end
                    scan_stamp = w.now;
                end
                r.result_value = low_mark;
            end
            default: begin
                r.result_value = low_mark;
            end
        endcase
        return r;
    endfunction

    // Check each result word, predict each accepted request word, and watch for a hang.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (rsp_due.size() == 0) begin
                    $error("result word with nothing pending: result_value %h order_error %b",
                           o_rsp.result_value, o_rsp.order_error);
                    n_fail++;
                end else begin
                    want = rsp_due.pop_front();
                    if (o_rsp.result_value !== want.result_value) begin
                        $error("result_value expected %h actual %h",
                               want.result_value, o_rsp.result_value);
                        n_fail++;
                    end
                    if (o_rsp.order_error !== want.order_error) begin
                        $error("order_error expected %b actual %b",
                               want.order_error, o_rsp.order_error);
                        n_fail++;
                    end
                    n_checked++;
                end
            end
            if (i_start && !o_busy) begin
                rsp_due.push_back(predict_word(i_req));
                n_words++;
                case (i_req.kind)
                    KIND_ALLOC:   n_alloc++;
                    KIND_PUBLISH: n_publish++;
                    KIND_QUERY:   n_query++;
                    default:      n_unused++;
                endcase
            end
            if (o_done || (i_start && !o_busy)) begin
                stall_run = 0;
            end else begin
                stall_run++;
            end
            if (stall_run >= STALL_LIMIT) begin
                $display("Watchdog expired with %0d results pending.", rsp_due.size());
                $display("[txn_timestamp_watermark_manager_core] ERROR");
                $finish;
            end
        end
    end

    // Write one configuration register while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        apply_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one request word, after a random gap unless the sender is quiet, and wait until it is taken.
    task automatic send_word(input t_req w);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= w;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Stop offering words and wait until every owed result has arrived.
    task automatic settle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (rsp_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_req make_word(logic [1:0] kind, logic [5:0] tid,
                                       logic [63:0] ts, logic [63:0] now);
        t_req w;
        w.kind     = kind;
        w.thr_idx  = tid;
        w.ts_value = ts;
        w.now      = now;
        return w;
    endfunction

    // Random request word: a mostly advancing clock and mostly rising
    // timestamps per thread, with jumps, drops and idle marks mixed in.
    function automatic t_req gen_word();
        t_req        w;
        int unsigned pick;
        logic [63:0] base;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            sys_now = sys_now + 64'($urandom_range(0, 40));
        end else if (pick < 85) begin
            sys_now = sys_now + {32'd0, $urandom};
        end else if (pick < 95) begin
            sys_now = {$urandom, $urandom};
        end
        w.now = sys_now;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            w.kind = KIND_ALLOC;
        end else if (pick < 65) begin
            w.kind = KIND_PUBLISH;
        end else if (pick < 96) begin
            w.kind = KIND_QUERY;
        end else begin
            w.kind = KIND_UNUSED;
        end
        w.thr_idx  = ($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom);
        w.ts_value = {$urandom, $urandom};
        if (w.kind == KIND_PUBLISH) begin
            base = (pub_last[w.thr_idx] == IDLE_TS) ? sys_now : pub_last[w.thr_idx];
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                w.ts_value = base + 64'($urandom_range(0, 100));
            end else if (pick < 75) begin
                w.ts_value = base - 64'($urandom_range(1, 100));
            end else if (pick < 85) begin
                w.ts_value = IDLE_TS;
            end
            pub_last[w.thr_idx] = w.ts_value;
        end
        return w;
    endfunction

    // Draw a full register setting; unused upper data bits carry noise.
    task automatic randomize_setup();
        logic [CFG_DATA_W-1:0] d;
        int unsigned           pick;
        d = $urandom;
        d[1:0] = 2'($urandom_range(0, 3));
        write_reg(CFG_TS_MODE, d);
        d = $urandom;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            d[15:0] = 16'd0;
        end else if (pick == 1) begin
            d[15:0] = 16'hFFFF;
        end else if (pick == 2) begin
            d[15:0] = 16'd1;
        end
        write_reg(CFG_BATCH_SIZE, d);
        for (int k = 0; k < 2; k++) begin
            d = $urandom;
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                d[6:0] = 7'd0;
            end else if (pick < 3) begin
                d[6:0] = 7'd127;
            end else if (pick < 6) begin
                d[6:0] = 7'd64;
            end else if (pick < 9) begin
                d[6:0] = 7'd1;
            end else begin
                d[6:0] = 7'($urandom_range(1, 64));
            end
            write_reg(k == 0 ? CFG_THREAD_COUNT : CFG_LOGGER_COUNT, d);
        end
        d = $urandom;
        d[0] = ($urandom_range(0, 3) == 0);
        write_reg(CFG_RECOVER_MODE, d);
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            d = 32'($urandom_range(0, 30));
        end else if (pick < 6) begin
            d = 32'd0;
        end else if (pick < 8) begin
            d = '1;
        end else begin
            d = $urandom;
        end
        write_reg(CFG_MIN_INTERVAL, d);
        n_setups++;
    endtask

    // Counter source after reset and a query that is too early to rescan.
    task automatic test_reset_state();
        send_word(make_word(KIND_ALLOC, 6'd0, 64'd0, 64'd0));
        send_word(make_word(KIND_ALLOC, 6'd63, IDLE_TS, IDLE_TS));
        send_word(make_word(KIND_QUERY, 6'd0, 64'd0, 64'd0));
        settle();
    endtask

    // Pre-increment, batch and clock sources, batch extremes and clock scaling extremes.
    task automatic test_timestamp_sources();
        write_reg(CFG_TS_MODE, CFG_DATA_W'(TS_PRE_INC));
        send_word(make_word(KIND_ALLOC, 6'd0, 64'd0, 64'd0));
        settle();
        write_reg(CFG_TS_MODE, CFG_DATA_W'(TS_FETCH_BATCH));
        write_reg(CFG_BATCH_SIZE, 32'h0000_FFFF);
        send_word(make_word(KIND_ALLOC, 6'd1, 64'd0, 64'd0));
        send_word(make_word(KIND_ALLOC, 6'd2, 64'd0, 64'd0));
        settle();
        // A zero batch size hands out the same value without advancing.
        write_reg(CFG_BATCH_SIZE, 32'd0);
        send_word(make_word(KIND_ALLOC, 6'd3, 64'd0, 64'd0));
        settle();
        // Clock source: the product wraps at 64 bits.
        write_reg(CFG_TS_MODE, CFG_DATA_W'(TS_NOW_SCALED));
        send_word(make_word(KIND_ALLOC, 6'd63, 64'd0, IDLE_TS));
        send_word(make_word(KIND_ALLOC, 6'd0, 64'd0, 64'd0));
        settle();
        write_reg(CFG_THREAD_COUNT, 32'd0);
        send_word(make_word(KIND_ALLOC, 6'd1, 64'd0, 64'd5));
        settle();
        write_reg(CFG_THREAD_COUNT, 32'd127);
        send_word(make_word(KIND_ALLOC, 6'd42, 64'd0, {$urandom, $urandom}));
        settle();
        write_reg(CFG_THREAD_COUNT, 32'd64);
        write_reg(CFG_TS_MODE, CFG_DATA_W'(TS_FETCH_ONE));
        write_reg(CFG_BATCH_SIZE, 32'd1);
    endtask

    // Rising, falling and idle publishes on one thread entry, then a publish to thread 0.
    task automatic test_publish_order();
        send_word(make_word(KIND_PUBLISH, 6'd5, 64'd100, 64'd0));
        send_word(make_word(KIND_PUBLISH, 6'd5, 64'd50, 64'd0));
        send_word(make_word(KIND_PUBLISH, 6'd5, IDLE_TS, 64'd0));
        send_word(make_word(KIND_PUBLISH, 6'd5, 64'd0, 64'd0));
        send_word(make_word(KIND_PUBLISH, 6'd0, 64'd10, 64'd0));
        settle();
    endtask

    // Watermark rescans: thread filter, interval, clock wrap and an empty scan.
    task automatic test_rescan_interval();
        send_word(make_word(KIND_QUERY, 6'd1, 64'd0, 64'd100));
        send_word(make_word(KIND_QUERY, 6'd0, 64'd0, 64'd100));
        send_word(make_word(KIND_PUBLISH, 6'd5, 64'd200, 64'd0));
        send_word(make_word(KIND_QUERY, 6'd0, 64'd0, 64'd200));
        settle();
        write_reg(CFG_MIN_INTERVAL, '1);
        send_word(make_word(KIND_PUBLISH, 6'd0, 64'd300, 64'd0));
        send_word(make_word(KIND_QUERY, 6'd0, 64'd0, 64'd201));
        send_word(make_word(KIND_QUERY, 6'd0, 64'd0, 64'd0));
        settle();
        // Scanning no threads raises the watermark to the idle value.
        write_reg(CFG_THREAD_COUNT, 32'd0);
        send_word(make_word(KIND_QUERY, 6'd0, 64'd0, IDLE_TS));
        settle();
        write_reg(CFG_THREAD_COUNT, 32'd64);
        write_reg(CFG_MIN_INTERVAL, 32'd0);
    endtask

    // Recovery mode: each publish resets the watermark to the logger minimum.
    task automatic test_recovery_scan();
        write_reg(CFG_RECOVER_MODE, 32'd1);
        send_word(make_word(KIND_PUBLISH, 6'd0, 64'd5, 64'd0));
        settle();
        write_reg(CFG_LOGGER_COUNT, 32'd64);
        send_word(make_word(KIND_PUBLISH, 6'd63, 64'd1, 64'd0));
        send_word(make_word(KIND_QUERY, 6'd0, 64'd0, 64'd7));
        send_word(make_word(KIND_UNUSED, 6'd9, IDLE_TS, IDLE_TS));
        settle();
        write_reg(CFG_LOGGER_COUNT, 32'd0);
        send_word(make_word(KIND_PUBLISH, 6'd1, 64'd7, 64'd0));
        settle();
        write_reg(CFG_LOGGER_COUNT, 32'd127);
        send_word(make_word(KIND_PUBLISH, 6'd2, 64'd3, 64'd0));
        settle();
        write_reg(CFG_RECOVER_MODE, 32'd0);
        write_reg(CFG_LOGGER_COUNT, 32'd1);
    endtask

    // Random traffic over several random register settings.
    task automatic test_random_traffic();
        for (int p = 0; p < RAND_PHASES; p++) begin
            randomize_setup();
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (n % 25 == 0) begin
                    quiet_sender = ($urandom_range(0, 9) < 3);
                end
                send_word(gen_word());
            end
            settle();
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_req        <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        quiet_sender = 1'b0;
        sys_now      = 64'd1000;
        n_fail       = 0;
        n_checked    = 0;
        n_words      = 0;
        n_alloc      = 0;
        n_publish    = 0;
        n_query      = 0;
        n_unused     = 0;
        n_setups     = 0;
        stall_run    = 0;
        reset_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_timestamp_sources();
        test_publish_order();
        test_rescan_interval();
        test_recovery_scan();
        test_random_traffic();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Checked %0d results for %0d words: %0d allocations, %0d publishes,",
                 n_checked, n_words, n_alloc, n_publish);
        $display("%0d queries and %0d unused kinds; all timestamp sources, rescans and",
                 n_query, n_unused);
        $display("recovery scans ran under %0d random settings.", n_setups);
        if (n_fail == 0 && rsp_due.size() == 0) begin
            $display("[txn_timestamp_watermark_manager_core] OK");
        end else begin
            $display("[txn_timestamp_watermark_manager_core] ERROR");
        end
        $finish;
    end

endmodule
